@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ILH_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ILH_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

@@ rtl/core/ilh_pkg.sv @@
`default_nettype none
package ilh_pkg;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_END_ROUND,
		OP_END_GAME,
		OP_SEND
	} op_t;

	typedef struct packed {
		op_t        operation;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic       write_ready;
		logic       start_push;
		logic [2:0] ball_row;
		logic       ball_dir;
		logic [2:0] ball_speed;
	} in_item_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       led_on;
		logic       start_game;
		logic       have_ball;
		logic       round_ended;
		logic       payload_valid;
		logic       game_ended;
		logic [3:0] rx_row;
		logic       rx_dir;
		logic [2:0] rx_speed;
	} out_item_t;

	typedef struct packed {
		logic advance;
		logic step;
	} stage_ctrl_t;

	localparam logic [7:0] CODE_BLANK     = 8'hFF;
	localparam logic [7:0] CODE_START     = 8'hFE;
	localparam logic [7:0] CODE_START_ACK = 8'hFD;
	localparam logic [7:0] CODE_END       = 8'hFC;
	localparam logic [7:0] CODE_END_ACK   = 8'hFB;
	localparam logic [7:0] CODE_GAME_OVER = 8'hFA;
	localparam logic [7:0] CODE_PAY_ACK   = 8'hD0;

endpackage
`default_nettype wire

@@ rtl/core/ilh_in_stage.sv @@
`default_nettype none
module ilh_in_stage (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       item_valid,
	output logic                      item_ready,
	input  wire ilh_pkg::in_item_t    item,
	input  wire ilh_pkg::stage_ctrl_t ctrl,
	output logic                      valid_s1,
	output ilh_pkg::in_item_t         item_s1
);
	import ilh_pkg::*;

	assign item_ready = !valid_s1 || ctrl.advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/ilh_engine.sv @@
`default_nettype none
module ilh_engine (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire ilh_pkg::stage_ctrl_t ctrl,
	input  wire ilh_pkg::in_item_t    item_s1,
	output ilh_pkg::out_item_t        result_q
);
	import ilh_pkg::*;

	typedef enum logic [2:0] {
		LS_START_REC,
		LS_START_SEND,
		LS_RECEIVING,
		LS_WAITING,
		LS_SENDING,
		LS_END_ROUND,
		LS_GAME_OVER
	} link_state_t;

	link_state_t link_q, link_d;
	logic [2:0]  seq_q, seq_d;
	logic [7:0]  held_q, held_d;
	logic        phase_q, phase_d;
	logic [3:0]  row_q, row_d;
	logic        dir_q, dir_d;
	logic [2:0]  speed_q, speed_d;
	out_item_t   res_d;

	logic        slot;
	logic [7:0]  held_t;
	logic [2:0]  last;
	logic [2:0]  seq_inc;
	logic [2:0]  seq_s;
	logic        hi_seq;
	logic        hi_last;
	logic        go_rx;

	always_comb begin
		link_d  = link_q;
		seq_d   = seq_q;
		held_d  = held_q;
		phase_d = phase_q;
		row_d   = row_q;
		dir_d   = dir_q;
		speed_d = speed_q;
		res_d   = '0;
		seq_s   = seq_q;
		go_rx   = 1'b0;

		slot    = phase_q & item_s1.write_ready;
		held_t  = item_s1.rx_valid ? item_s1.rx_byte : held_q;
		last    = seq_q - 3'd1;
		seq_inc = seq_q + 3'd1;
		hi_seq  = (held_t[7:4] == {1'b0, seq_q});
		hi_last = (held_t[7:4] == {1'b0, last});

		case (item_s1.operation)
			OP_END_ROUND: begin
				link_d = LS_END_ROUND;
			end
			OP_END_GAME: begin
				link_d = LS_GAME_OVER;
			end
			OP_SEND: begin
				if (link_q == LS_WAITING) begin
					link_d  = LS_SENDING;
					if (seq_q[0]) begin
						seq_d = seq_inc;
					end
					row_d   = {1'b0, item_s1.ball_row};
					dir_d   = item_s1.ball_dir;
					speed_d = item_s1.ball_speed;
				end
			end
			default: begin
				// tick: slot opens on odd phase, held open until the transmitter takes it
				phase_d = ~phase_q | ~item_s1.write_ready;
				held_d  = held_t;
				case (link_q)
					LS_START_REC: begin
						res_d.led_on = 1'b1;
						if (held_t == CODE_START) begin
							link_d           = LS_RECEIVING;
							res_d.start_game = 1'b1;
						end else if (held_t == CODE_END && slot) begin
							held_d         = CODE_BLANK;
							res_d.tx_valid = 1'b1;
							res_d.tx_byte  = CODE_END_ACK;
						end else if (item_s1.start_push) begin
							link_d = LS_START_SEND;
						end
					end
					LS_START_SEND: begin
						res_d.led_on = 1'b1;
						if (held_t == CODE_START_ACK) begin
							held_d           = CODE_BLANK;
							link_d           = LS_WAITING;
							res_d.start_game = 1'b1;
							res_d.have_ball  = 1'b1;
						end else if (held_t == CODE_END && slot) begin
							held_d         = CODE_BLANK;
							res_d.tx_valid = 1'b1;
							res_d.tx_byte  = CODE_END_ACK;
						end else if (held_t == CODE_START) begin
							held_d = CODE_BLANK;
							link_d = LS_START_REC;
						end else if (slot) begin
							res_d.tx_valid = 1'b1;
							res_d.tx_byte  = CODE_START;
						end
					end
					LS_RECEIVING: begin
						if (held_t == CODE_START && slot) begin
							res_d.tx_valid = 1'b1;
							res_d.tx_byte  = CODE_START_ACK;
							held_d         = CODE_BLANK;
						end else if (held_t == CODE_GAME_OVER) begin
							held_d           = CODE_BLANK;
							link_d           = LS_GAME_OVER;
							res_d.game_ended = 1'b1;
						end else if (held_t == CODE_END) begin
							held_d            = CODE_BLANK;
							link_d            = LS_START_REC;
							res_d.round_ended = 1'b1;
						end else if (hi_seq) begin
							if (slot) begin
								held_d         = CODE_BLANK;
								res_d.tx_valid = 1'b1;
								res_d.tx_byte  = CODE_PAY_ACK | {5'd0, seq_q};
							end
							if (!seq_q[0]) begin
								row_d = held_t[3:0];
							end else begin
								dir_d               = held_t[3];
								speed_d             = held_t[2:0];
								link_d              = LS_WAITING;
								res_d.payload_valid = 1'b1;
							end
							seq_d = seq_inc;
						end else if (hi_last && slot) begin
							held_d         = CODE_BLANK;
							res_d.tx_valid = 1'b1;
							res_d.tx_byte  = CODE_PAY_ACK | {5'd0, last};
						end
					end
					LS_WAITING: begin
						if (hi_last && slot) begin
							held_d         = CODE_BLANK;
							res_d.tx_valid = 1'b1;
							res_d.tx_byte  = CODE_PAY_ACK | {5'd0, last};
						end
					end
					LS_SENDING: begin
						if (held_t[7:4] == CODE_PAY_ACK[7:4] && held_t[3:0] == {1'b0, seq_q})
						begin
							held_d = CODE_BLANK;
							seq_s  = seq_inc;
							if (seq_q[0]) begin
								go_rx  = 1'b1;
								link_d = LS_RECEIVING;
							end
						end
						seq_d = seq_s;
						if (slot && !go_rx) begin
							res_d.tx_valid = 1'b1;
							res_d.tx_byte  = seq_s[0] ? {1'b0, seq_s, dir_q, speed_q}
							                          : {1'b0, seq_s, row_q};
						end
					end
					LS_END_ROUND: begin
						if (held_t == CODE_END_ACK) begin
							link_d = LS_START_REC;
							held_d = CODE_BLANK;
						end else if (slot) begin
							res_d.tx_valid = 1'b1;
							res_d.tx_byte  = CODE_END;
						end
					end
					LS_GAME_OVER: begin
						if (slot) begin
							res_d.tx_valid = 1'b1;
							res_d.tx_byte  = CODE_GAME_OVER;
						end
					end
					default: begin
					end
				endcase
			end
		endcase

		if (res_d.payload_valid) begin
			res_d.rx_row   = row_d;
			res_d.rx_dir   = dir_d;
			res_d.rx_speed = speed_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q   <= LS_START_REC;
			seq_q    <= 3'd0;
			held_q   <= CODE_BLANK;
			phase_q  <= 1'b0;
			row_q    <= 4'd0;
			dir_q    <= 1'b0;
			speed_q  <= 3'd0;
			result_q <= '0;
		end else if (ctrl.step) begin
			link_q   <= link_d;
			seq_q    <= seq_d;
			held_q   <= held_d;
			phase_q  <= phase_d;
			row_q    <= row_d;
			dir_q    <= dir_d;
			speed_q  <= speed_d;
			result_q <= res_d;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/ir_link_handshake_arq.sv @@
// A transaction accepted by the input stage is registered there, then in the result register
// once the result side can take it, with result_valid high from then on.
// Throughput: one transaction per cycle unless result_ready stalls the result register.
// The result register parts the two sides; the input stage stalls only when it is full
// and the result register holds a result that is not taken.
// Reset (arst_n low, asynchronous): start-receive state, sequence 0, held byte blank.
`default_nettype none
module ir_link_handshake_arq (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     item_valid,
	output logic                    item_ready,
	input  wire ilh_pkg::in_item_t  item,
	output logic                    result_valid,
	input  wire                     result_ready,
	output ilh_pkg::out_item_t      result
);
	import ilh_pkg::*;

	stage_ctrl_t ctrl;
	logic        valid_s1;
	in_item_t    item_s1;
	logic        result_valid_q;

	assign ctrl.advance = !result_valid_q || result_ready;
	assign ctrl.step    = valid_s1 && ctrl.advance;

	ilh_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.ctrl       (ctrl),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	ilh_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.item_s1  (item_s1),
		.result_q (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (ctrl.advance) begin
			result_valid_q <= valid_s1;
		end
	end

	assign result_valid = result_valid_q;

endmodule
`default_nettype wire

@@ rtl/core/ilh_checker.sv @@
`default_nettype none
`include "assert_macros.svh"
module ilh_checker (
	input wire                     clk,
	input wire                     arst_n,
	input wire                     item_valid,
	input wire                     item_ready,
	input wire ilh_pkg::in_item_t  item,
	input wire                     result_valid,
	input wire                     result_ready,
	input wire ilh_pkg::out_item_t result
);
	import ilh_pkg::*;

	`ILH_ASSERT_NEXT(a_item_held, item_valid && !item_ready,
		item_valid && $stable(item))
	`ILH_ASSERT_NEXT(a_result_held, result_valid && !result_ready,
		result_valid && $stable(result))
	`ILH_ASSERT_IMPL(a_blank_fields, result_valid,
		(result.tx_valid || result.tx_byte == 8'd0) && (result.payload_valid ||
		(result.rx_row == 4'd0 && !result.rx_dir && result.rx_speed == 3'd0)))
	`ILH_ASSERT_IMPL(a_ball_with_start, result_valid && result.have_ball,
		result.start_game && result.led_on)
	`ILH_ASSERT_IMPL(a_one_event, result_valid,
		$countones({result.start_game, result.round_ended, result.payload_valid,
		result.game_ended}) <= 1)

endmodule

bind ir_link_handshake_arq ilh_checker u_ilh_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;
	import ilh_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned LOG_LIMIT   = 100;

	typedef enum logic [2:0] {
		LS_START_REC,
		LS_START_SEND,
		LS_RECEIVING,
		LS_WAITING,
		LS_SENDING,
		LS_END_ROUND,
		LS_GAME_OVER
	} link_state_t;

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	logic      item_valid   = 1'b0;
	logic      item_ready;
	in_item_t  item         = '0;
	logic      result_valid;
	logic      result_ready = 1'b0;
	out_item_t result;

	ir_link_handshake_arq dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// Link engine mirror
	link_state_t lnk_state;
	logic [2:0]  lnk_seq;
	logic [7:0]  lnk_held;
	logic        lnk_phase;
	logic [3:0]  lnk_row;
	logic        lnk_dir;
	logic [2:0]  lnk_speed;

	out_item_t   expected_results[$];
	int unsigned error_count  = 0;
	int unsigned result_count = 0;
	int unsigned cycle_count  = 0;
	int          send_mode    = 0;
	int          recv_mode    = 0;
	int unsigned hold_len     = 0;
	int unsigned hold_req     = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("ERROR: timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic int draw_gap(int mode);
		case (mode)
			0: return 0;
			1: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 17)) : 0;
			default: return int'($urandom_range(0, 17));
		endcase
	endfunction

	function automatic out_item_t link_predict(in_item_t it);
		out_item_t  r;
		logic       slot;
		logic       done;
		logic [2:0] s;
		logic [2:0] prev;
		logic [3:0] hi;
		r = '0;
		slot = 1'b0;
		done = 1'b0;
		if (it.operation == OP_END_ROUND) begin
			lnk_state = LS_END_ROUND;
			return r;
		end
		if (it.operation == OP_END_GAME) begin
			lnk_state = LS_GAME_OVER;
			return r;
		end
		if (it.operation == OP_SEND) begin
			if (lnk_state == LS_WAITING) begin
				lnk_state = LS_SENDING;
				if (lnk_seq[0])
					lnk_seq = lnk_seq + 3'd1;
				lnk_row   = {1'b0, it.ball_row};
				lnk_dir   = it.ball_dir;
				lnk_speed = it.ball_speed;
			end
			return r;
		end

		s = lnk_seq;
		lnk_phase = ~lnk_phase;
		if (!lnk_phase) begin
			if (it.write_ready)
				slot = 1'b1;
			else
				lnk_phase = 1'b1;
		end
		if (it.rx_valid)
			lnk_held = it.rx_byte;
		prev = s - 3'd1;
		hi = lnk_held[7:4];

		case (lnk_state)
			LS_START_REC: begin
				r.led_on = 1'b1;
				if (lnk_held == CODE_START) begin
					lnk_state = LS_RECEIVING;
					r.start_game = 1'b1;
				end else if (lnk_held == CODE_END && slot) begin
					lnk_held = CODE_BLANK;
					r.tx_valid = 1'b1;
					r.tx_byte = CODE_END_ACK;
				end else if (it.start_push) begin
					lnk_state = LS_START_SEND;
				end
			end
			LS_START_SEND: begin
				r.led_on = 1'b1;
				if (lnk_held == CODE_START_ACK) begin
					lnk_held = CODE_BLANK;
					lnk_state = LS_WAITING;
					r.start_game = 1'b1;
					r.have_ball = 1'b1;
				end else if (lnk_held == CODE_END && slot) begin
					lnk_held = CODE_BLANK;
					r.tx_valid = 1'b1;
					r.tx_byte = CODE_END_ACK;
				end else if (lnk_held == CODE_START) begin
					lnk_held = CODE_BLANK;
					lnk_state = LS_START_REC;
				end else if (slot) begin
					r.tx_valid = 1'b1;
					r.tx_byte = CODE_START;
				end
			end
			LS_RECEIVING: begin
				if (lnk_held == CODE_START && slot) begin
					r.tx_valid = 1'b1;
					r.tx_byte = CODE_START_ACK;
					lnk_held = CODE_BLANK;
				end else if (lnk_held == CODE_GAME_OVER) begin
					lnk_held = CODE_BLANK;
					lnk_state = LS_GAME_OVER;
					r.game_ended = 1'b1;
				end else if (lnk_held == CODE_END) begin
					lnk_held = CODE_BLANK;
					lnk_state = LS_START_REC;
					r.round_ended = 1'b1;
				end else if (hi == {1'b0, s}) begin
					if (!s[0]) begin
						lnk_row = lnk_held[3:0];
					end else begin
						lnk_dir = lnk_held[3];
						lnk_speed = lnk_held[2:0];
						lnk_state = LS_WAITING;
						r.payload_valid = 1'b1;
					end
					if (slot) begin
						lnk_held = CODE_BLANK;
						r.tx_valid = 1'b1;
						r.tx_byte = CODE_PAY_ACK | {5'd0, s};
					end
					s = s + 3'd1;
				end else if (hi == {1'b0, prev} && slot) begin
					lnk_held = CODE_BLANK;
					r.tx_valid = 1'b1;
					r.tx_byte = CODE_PAY_ACK | {5'd0, prev};
				end
			end
			LS_WAITING: begin
				if (hi == {1'b0, prev} && slot) begin
					lnk_held = CODE_BLANK;
					r.tx_valid = 1'b1;
					r.tx_byte = CODE_PAY_ACK | {5'd0, prev};
				end
			end
			LS_SENDING: begin
				if (lnk_held[7:4] == CODE_PAY_ACK[7:4] && lnk_held[3:0] == {1'b0, s}) begin
					lnk_held = CODE_BLANK;
					if (s[0]) begin
						lnk_state = LS_RECEIVING;
						done = 1'b1;
					end
					s = s + 3'd1;
				end
				if (!done && slot) begin
					r.tx_valid = 1'b1;
					if (!s[0])
						r.tx_byte = {1'b0, s, lnk_row};
					else
						r.tx_byte = {1'b0, s, lnk_dir, lnk_speed};
				end
			end
			LS_END_ROUND: begin
				if (lnk_held == CODE_END_ACK) begin
					lnk_state = LS_START_REC;
					lnk_held = CODE_BLANK;
				end else if (slot) begin
					r.tx_valid = 1'b1;
					r.tx_byte = CODE_END;
				end
			end
			LS_GAME_OVER: begin
				if (slot) begin
					r.tx_valid = 1'b1;
					r.tx_byte = CODE_GAME_OVER;
				end
			end
			default: begin
			end
		endcase
		lnk_seq = s;
		if (r.payload_valid) begin
			r.rx_row = lnk_row;
			r.rx_dir = lnk_dir;
			r.rx_speed = lnk_speed;
		end
		return r;
	endfunction

	function automatic in_item_t tick_item(logic rxv, logic [7:0] rxb, logic wr, logic push);
		in_item_t it;
		it = '0;
		it.operation = OP_TICK;
		it.rx_valid = rxv;
		it.rx_byte = rxb;
		it.write_ready = wr;
		it.start_push = push;
		return it;
	endfunction

	function automatic in_item_t cmd_item(op_t op, logic [2:0] row, logic dir, logic [2:0] speed);
		in_item_t it;
		it = '0;
		it.operation = op;
		it.ball_row = row;
		it.ball_dir = dir;
		it.ball_speed = speed;
		return it;
	endfunction

	// Partner side: mostly well-formed replies to the current link state, some noise
	function automatic in_item_t pick_link_item();
		in_item_t   it;
		int         roll;
		logic [2:0] prev;
		logic [3:0] nib;
		it = '0;
		it.operation = OP_TICK;
		it.rx_byte = 8'($urandom_range(0, 255));
		it.write_ready = ($urandom_range(0, 99) < 85);
		it.ball_row = 3'($urandom_range(0, 7));
		it.ball_dir = 1'($urandom_range(0, 1));
		it.ball_speed = 3'($urandom_range(0, 7));
		nib = 4'($urandom_range(0, 15));
		prev = lnk_seq - 3'd1;
		if ($urandom_range(0, 99) < 15) begin
			it.rx_valid = 1'($urandom_range(0, 1));
			it.start_push = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 3) == 0)
				it.operation = op_t'($urandom_range(0, 3));
			return it;
		end
		roll = $urandom_range(0, 99);
		case (lnk_state)
			LS_START_REC: begin
				if (roll < 20) begin
					it.rx_valid = 1'b1;
					it.rx_byte = CODE_START;
				end else if (roll < 30) begin
					it.rx_valid = 1'b1;
					it.rx_byte = CODE_END;
				end else if (roll < 50) begin
					it.start_push = 1'b1;
				end
			end
			LS_START_SEND: begin
				it.rx_valid = (roll < 35);
				if (roll < 25)
					it.rx_byte = CODE_START_ACK;
				else if (roll < 30)
					it.rx_byte = CODE_START;
				else
					it.rx_byte = CODE_END;
			end
			LS_RECEIVING: begin
				it.rx_valid = (roll < 73);
				if (roll < 50)
					it.rx_byte = {1'b0, lnk_seq, nib};
				else if (roll < 60)
					it.rx_byte = {1'b0, prev, nib};
				else if (roll < 65)
					it.rx_byte = CODE_END;
				else if (roll < 68)
					it.rx_byte = CODE_GAME_OVER;
				else
					it.rx_byte = CODE_START;
			end
			LS_WAITING: begin
				if (roll < 35) begin
					it.operation = OP_SEND;
				end else if (roll < 45) begin
					it.rx_valid = 1'b1;
					it.rx_byte = {1'b0, prev, nib};
				end else if (roll < 50) begin
					it.operation = OP_END_ROUND;
				end else if (roll < 52) begin
					it.operation = OP_END_GAME;
				end
			end
			LS_SENDING: begin
				if (roll < 40) begin
					it.rx_valid = 1'b1;
					it.rx_byte = CODE_PAY_ACK | {5'd0, lnk_seq};
				end else if (roll < 45) begin
					it.rx_valid = 1'b1;
					it.rx_byte = {CODE_PAY_ACK[7:4], nib};
				end else if (roll < 47) begin
					it.operation = OP_END_ROUND;
				end
			end
			LS_END_ROUND: begin
				if (roll < 35) begin
					it.rx_valid = 1'b1;
					it.rx_byte = CODE_END_ACK;
				end
			end
			LS_GAME_OVER: begin
				if (roll < 20)
					it.operation = OP_END_ROUND;
			end
			default: begin
			end
		endcase
		return it;
	endfunction

	task automatic report_error(string msg);
		error_count++;
		if (error_count <= LOG_LIMIT)
			$display("ERROR: %s", msg);
	endtask

	task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
		if (got !== want)
			report_error($sformatf("transaction %0d: %s got 0x%0h want 0x%0h",
				result_count, name, got, want));
	endtask

	task automatic check_result(out_item_t got);
		out_item_t want;
		result_count++;
		if (expected_results.size() == 0) begin
			report_error($sformatf("transaction %0d: result with nothing expected", result_count));
			return;
		end
		want = expected_results.pop_front();
		compare_field("tx_valid", 8'(got.tx_valid), 8'(want.tx_valid));
		compare_field("tx_byte", got.tx_byte, want.tx_byte);
		compare_field("led_on", 8'(got.led_on), 8'(want.led_on));
		compare_field("start_game", 8'(got.start_game), 8'(want.start_game));
		compare_field("have_ball", 8'(got.have_ball), 8'(want.have_ball));
		compare_field("round_ended", 8'(got.round_ended), 8'(want.round_ended));
		compare_field("payload_valid", 8'(got.payload_valid), 8'(want.payload_valid));
		compare_field("game_ended", 8'(got.game_ended), 8'(want.game_ended));
		compare_field("rx_row", 8'(got.rx_row), 8'(want.rx_row));
		compare_field("rx_dir", 8'(got.rx_dir), 8'(want.rx_dir));
		compare_field("rx_speed", 8'(got.rx_speed), 8'(want.rx_speed));
	endtask

	// Result side: per-transaction stall, plus long hold-offs on request
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned recv_wait = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				check_result(result);
				recv_wait = draw_gap(recv_mode);
			end
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = hold_len;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (recv_wait != 0) begin
				recv_wait--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	task automatic send_item(in_item_t it);
		int gap;
		gap = draw_gap(send_mode);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (!item_ready);
		expected_results.push_back(link_predict(it));
	endtask

	task automatic wait_for_results();
		item_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_directed_link();
		in_item_t items[$];
		items.push_back(tick_item(1'b0, 8'h00, 1'b1, 1'b0));
		items.push_back(cmd_item(OP_SEND, 3'd7, 1'b1, 3'd7));
		items.push_back(tick_item(1'b1, CODE_END, 1'b0, 1'b0));
		items.push_back(tick_item(1'b0, 8'hFF, 1'b1, 1'b0));
		items.push_back(tick_item(1'b0, 8'h00, 1'b1, 1'b1));
		items.push_back(tick_item(1'b0, 8'h00, 1'b1, 1'b0));
		items.push_back(tick_item(1'b0, 8'h00, 1'b1, 1'b0));
		items.push_back(tick_item(1'b1, CODE_START_ACK, 1'b1, 1'b0));
		items.push_back(cmd_item(OP_SEND, 3'd7, 1'b1, 3'd7));
		items.push_back(tick_item(1'b0, 8'h00, 1'b1, 1'b0));
		items.push_back(tick_item(1'b0, 8'h00, 1'b1, 1'b0));
		items.push_back(tick_item(1'b1, CODE_PAY_ACK, 1'b1, 1'b0));
		items.push_back(tick_item(1'b0, 8'h00, 1'b0, 1'b0));
		items.push_back(tick_item(1'b0, 8'h00, 1'b1, 1'b0));
		items.push_back(tick_item(1'b1, CODE_PAY_ACK | 8'h01, 1'b1, 1'b0));
		items.push_back(tick_item(1'b1, 8'h2F, 1'b1, 1'b0));
		items.push_back(tick_item(1'b0, 8'h00, 1'b1, 1'b0));
		items.push_back(tick_item(1'b1, 8'h3F, 1'b1, 1'b0));
		items.push_back(tick_item(1'b1, 8'h3F, 1'b1, 1'b0));
		items.push_back(cmd_item(OP_END_ROUND, 3'd0, 1'b0, 3'd0));
		items.push_back(tick_item(1'b0, 8'h00, 1'b1, 1'b0));
		items.push_back(tick_item(1'b1, CODE_END_ACK, 1'b1, 1'b0));
		items.push_back(tick_item(1'b1, CODE_START, 1'b1, 1'b0));
		items.push_back(cmd_item(OP_END_GAME, 3'd0, 1'b0, 3'd0));
		items.push_back(tick_item(1'b0, 8'h00, 1'b1, 1'b0));
		foreach (items[i])
			send_item(items[i]);
		wait_for_results();
	endtask

	task automatic test_random_link();
		for (int blk = 0; blk < 10; blk++) begin
			send_mode = (blk == 0) ? 0 : (blk == 1) ? 2 : int'($urandom_range(0, 2));
			recv_mode = (blk == 0) ? 0 : (blk == 1) ? 2 : int'($urandom_range(0, 2));
			repeat (100) send_item(pick_link_item());
			// sender stands still until the link has drained
			if (blk % 2 == 1)
				wait_for_results();
		end
		wait_for_results();
	endtask

	task automatic test_result_backpressure();
		send_mode = 0;
		recv_mode = 1;
		hold_len = 250;
		hold_req++;
		repeat (60) send_item(pick_link_item());
		wait_for_results();
	endtask

	task automatic test_noise_items();
		in_item_t it;
		send_mode = 2;
		recv_mode = 2;
		repeat (200) begin
			it.operation = op_t'($urandom_range(0, 3));
			it.rx_valid = 1'($urandom_range(0, 1));
			it.rx_byte = 8'($urandom_range(0, 255));
			it.write_ready = 1'($urandom_range(0, 1));
			it.start_push = 1'($urandom_range(0, 1));
			it.ball_row = 3'($urandom_range(0, 7));
			it.ball_dir = 1'($urandom_range(0, 1));
			it.ball_speed = 3'($urandom_range(0, 7));
			send_item(it);
		end
		wait_for_results();
	endtask

	initial begin
		lnk_state = LS_START_REC;
		lnk_seq   = 3'd0;
		lnk_held  = CODE_BLANK;
		lnk_phase = 1'b0;
		lnk_row   = 4'd0;
		lnk_dir   = 1'b0;
		lnk_speed = 3'd0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_link();
		test_random_link();
		test_result_backpressure();
		test_noise_items();

		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ ir_link_handshake_arq.f @@
+incdir+rtl/core
rtl/core/ilh_pkg.sv
rtl/core/ilh_in_stage.sv
rtl/core/ilh_engine.sv
rtl/core/ir_link_handshake_arq.sv
rtl/core/ilh_checker.sv
dv/tb.sv
